// ----- rtl/core/skt_pkg.sv -----
`timescale 1ns / 1ps

package skt_pkg;

   // Default number of keyframe cells in the chain.
   localparam int CAPACITY_DEFAULT = 64;

   // Field widths of the request and response channels.
   localparam int REQ_W       = 3;
   localparam int INDEX_W     = 8;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int FOUND_W     = 6;
   localparam int TOTAL_W     = 7;
   localparam int REQ_TDATA_W = INDEX_W + 2 * DATA_W;
   localparam int RSP_FIELD_W = FOUND_W + 2 * DATA_W + TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_READ   = 3'd2,
      REQ_CHANGE = 3'd3,
      REQ_FIND   = 3'd4
   } req_code_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   // One stored keyframe: time and value, both signed Q16.16.
   typedef struct packed {
      logic signed [DATA_W-1:0] key_time;
      logic signed [DATA_W-1:0] key_value;
   } entry_type;

   // One response.
   typedef struct packed {
      status_type               status;
      logic [FOUND_W-1:0]       found_index;
      logic signed [DATA_W-1:0] read_time;
      logic signed [DATA_W-1:0] read_value;
      logic [TOTAL_W-1:0]       entry_total;
   } rsp_type;

endpackage

// ----- rtl/core/skt_cell.sv -----
`timescale 1ns / 1ps

module skt_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  skt_pkg::entry_type  entry_in,
   output skt_pkg::entry_type  entry_out
);
   import skt_pkg::*;

   entry_type entry_ff;

   // Take the neighbor's keyframe on every step of a pass.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ----- rtl/core/skt_ctrl.sv -----
`timescale 1ns / 1ps

module skt_ctrl #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [skt_pkg::REQ_W-1:0]           req_code,
   input  logic [skt_pkg::INDEX_W-1:0]         req_index,
   input  logic signed [skt_pkg::DATA_W-1:0]   req_time,
   input  logic signed [skt_pkg::DATA_W-1:0]   req_value,
   input  skt_pkg::entry_type                  head0,
   input  skt_pkg::entry_type                  head1,
   output skt_pkg::entry_type                  tail,
   output logic                                shift_en,
   output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output skt_pkg::rsp_type                    rsp
);
   import skt_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > INDEX_W) ? CW : INDEX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   req_code_type             op_ff, op_in;
   logic [INDEX_W-1:0]       idx_ff, idx_in;
   logic signed [DATA_W-1:0] time_ff, time_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IW-1:0]            step_ff, step_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     done_ff, done_in;
   entry_type                hold_ff, hold_in;
   logic [IW-1:0]            found_ff, found_in;
   entry_type                read_ff, read_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   req_code_type             code;
   logic                     rsp_free;
   logic                     in_range;
   logic                     at_idx;
   logic                     from_idx;
   logic                     below_count;
   logic                     at_count;
   logic                     greater;
   logic                     last_step;
   entry_type                new_entry;
   entry_type                tail_c;
   logic [CW-1:0]            count_now;
   logic [IW+FOUND_W-1:0]    found_wide;
   logic [CW+TOTAL_W-1:0]    total_wide;
   logic [CW+TOTAL_W-1:0]    total_now_wide;

   // Compares of the current step against the stored request.
   always_comb begin
      code        = req_code_type'(req_code);
      rsp_free    = !rsp_valid_ff || rsp_ready;
      in_range    = MW'(req_index) < MW'(count_ff);
      at_idx      = MW'(step_ff) == MW'(idx_ff);
      from_idx    = MW'(step_ff) >= MW'(idx_ff);
      below_count = CW'(step_ff) < count_ff;
      at_count    = CW'(step_ff) == count_ff;
      greater     = $signed(head0.key_time) > $signed(time_ff);
      last_step   = step_ff == IW'(CAPACITY - 1);
      new_entry   = '{key_time: time_ff, key_value: value_ff};
   end

   // Next state of the sequencer and of the entry that re-enters the chain.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      value_in     = value_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      hold_in      = hold_ff;
      found_in     = found_ff;
      read_in      = read_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      tail_c       = head0;
      count_now    = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            total_now_wide = (CW + TOTAL_W)'(count_ff);
            if (req_valid && rsp_free) begin
               op_in    = code;
               idx_in   = req_index;
               time_in  = req_time;
               value_in = req_value;
               step_in  = '0;
               done_in  = 1'b0;
               found_in = '0;
               read_in  = '0;
               // Requests that need no pass answer at once.
               rsp_in   = '{status: STATUS_OK, found_index: '0, read_time: '0,
                            read_value: '0, entry_total: total_now_wide[TOTAL_W-1:0]};
               case (code)
                  REQ_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_PASS;
                     end
                  end
                  REQ_REMOVE, REQ_READ, REQ_CHANGE, REQ_FIND: begin
                     if (!in_range) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_PASS;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_PASS: begin
            total_now_wide = '0;
            // Every entry passes the head once; it is rewritten into the tail.
            unique case (op_ff)
               REQ_INSERT: begin
                  if (!done_ff && (at_count || (below_count && greater))) begin
                     tail_c   = new_entry;
                     hold_in  = head0;
                     done_in  = 1'b1;
                     found_in = step_ff;
                  end else if (done_ff) begin
                     tail_c  = hold_ff;
                     hold_in = head0;
                  end
               end
               REQ_REMOVE: begin
                  if (from_idx) begin
                     tail_c = head1;
                  end
               end
               REQ_READ: begin
                  if (at_idx) begin
                     read_in = head0;
                  end
               end
               REQ_CHANGE: begin
                  if (at_idx) begin
                     tail_c = new_entry;
                  end
               end
               REQ_FIND: begin
                  if (!done_ff && from_idx && below_count && greater) begin
                     done_in  = 1'b1;
                     found_in = step_ff;
                  end
               end
               default: begin
                  tail_c = head0;
               end
            endcase
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // New fill count after the pass.
            if (op_ff == REQ_INSERT) begin
               count_now = count_ff + 1'b1;
            end else if (op_ff == REQ_REMOVE) begin
               count_now = count_ff - 1'b1;
            end
            total_now_wide = (CW + TOTAL_W)'(count_now);
            if (rsp_free) begin
               count_in       = count_now;
               rsp_in         = '{status: STATUS_OK, found_index: '0, read_time: '0,
                                  read_value: '0,
                                  entry_total: total_now_wide[TOTAL_W-1:0]};
               if (op_ff == REQ_INSERT || (op_ff == REQ_FIND && done_ff)) begin
                  rsp_in.found_index = found_wide[FOUND_W-1:0];
               end
               if (op_ff == REQ_FIND && !done_ff) begin
                  rsp_in.status = STATUS_NONE;
               end
               if (op_ff == REQ_READ) begin
                  rsp_in.read_time  = read_ff.key_time;
                  rsp_in.read_value = read_ff.key_value;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            total_now_wide = '0;
            state_in       = ST_IDLE;
         end
      endcase
   end

   assign found_wide = (IW + FOUND_W)'(found_ff);
   assign total_wide = (CW + TOTAL_W)'(count_ff);

   // Sequencer state, request copy and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         step_ff      <= step_in;
      end
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      time_ff  <= time_in;
      value_ff <= value_in;
      hold_ff  <= hold_in;
      found_ff <= found_in;
      read_ff  <= read_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE) && rsp_free;
   assign shift_en    = state_ff == ST_PASS;
   assign tail        = tail_c;
   assign entry_count = total_wide[CW-1:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp         = rsp_ff;

endmodule

// ----- rtl/core/sorted_keyframe_table.sv -----
`timescale 1ns / 1ps

// Insert (table not full) and remove, read, change or find with an index below the fill
// count: the chain of CAPACITY cells rotates once and the response is registered after
// the rotation; no new request is taken until that response is registered and free.
// Every other request is answered in the cycle after it is taken, one per cycle while rsp_tready holds.
// Reset clears the fill count, the sequencer and the response valid; cell contents are
// left as they are and are never read before being written.
module sorted_keyframe_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: index, key_time, key_value.
   input  logic [skt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // From bit 0: req_type.
   input  logic [skt_pkg::REQ_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: found_index, read_time, read_value, entry_total, zero fill.
   output logic [skt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // From bit 0: status.
   output logic [skt_pkg::STATUS_W-1:0]      rsp_tuser
);
   import skt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   entry_type       cell_q [CAPACITY];
   entry_type       tail;
   logic            shift_en;
   logic [CW-1:0]   entry_count;
   rsp_type         rsp;

   // Row of keyframe cells; each hands its entry to the lower neighbor.
   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         if (k == CAPACITY - 1) begin : g_last
            skt_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .entry_in  (tail),
               .entry_out (cell_q[k])
            );
         end else begin : g_mid
            skt_cell u_cell (
               .clock     (clock),
               .shift_en  (shift_en),
               .entry_in  (cell_q[k+1]),
               .entry_out (cell_q[k])
            );
         end
      end
   endgenerate

   // Sequencer at the head of the chain.
   skt_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_code    (req_tuser),
      .req_index   (req_tdata[INDEX_W-1:0]),
      .req_time    (req_tdata[INDEX_W+DATA_W-1:INDEX_W]),
      .req_value   (req_tdata[INDEX_W+2*DATA_W-1:INDEX_W+DATA_W]),
      .head0       (cell_q[0]),
      .head1       (cell_q[1]),
      .tail        (tail),
      .shift_en    (shift_en),
      .entry_count (entry_count),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   // Response packing.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.entry_total, rsp.read_value,
                       rsp.read_time, rsp.found_index};
   assign rsp_tuser = rsp.status;

`ifndef NO_ASSERTIONS
   // No request is taken while the chain is rotating.
   assert property (@(posedge clock) disable iff (reset) shift_en |-> !req_tready)
      else $error("request taken during a pass");

   // A full answer only comes from a table holding CAPACITY keyframes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_FULL) |-> (entry_count == CW'(CAPACITY)))
      else $error("table full reported below capacity");

   // The fill count changes only together with a response.
   assert property (@(posedge clock) disable iff (reset)
      (entry_count != $past(entry_count)) |-> rsp_tvalid)
      else $error("fill count changed without a response");

   // The fill count never exceeds the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      entry_count <= CW'(CAPACITY))
      else $error("fill count above capacity");
`endif

endmodule
